/* design/gne_pkg.sv */
`timescale 1ns / 1ps
// gne_pkg: shared types, constants and helpers of the grid neighbour expander
// no dependencies; used by every other file of the block but gne_queue and gne_isqrt

package gne_pkg;

	localparam int unsigned GRID_SIDE_DEF = 1024;
	localparam int unsigned COST_FRAC_DEF = 8;
	localparam int unsigned FIELD_SPAN    = 1024;
	localparam int unsigned ROW_W         = 10;
	localparam int unsigned COST_W        = 24;
	localparam int unsigned MASK_W        = 8;
	localparam int unsigned WEIGHT_W      = 12;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned CFG_DATA_W    = 12;
	localparam int unsigned QUEUE_DEPTH   = 4;

	// sqrt(2) in unsigned Q2.32
	localparam logic [33:0] SQRT2_Q32 = 34'd6074001000;
	localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFF;

	// neighbour codes, also bit positions in the free mask
	localparam logic [2:0] DIR_UP    = 3'd0;
	localparam logic [2:0] DIR_DOWN  = 3'd1;
	localparam logic [2:0] DIR_LEFT  = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_UL    = 3'd4;
	localparam logic [2:0] DIR_UR    = 3'd5;
	localparam logic [2:0] DIR_DL    = 3'd6;
	localparam logic [2:0] DIR_DR    = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_METRIC      = 3'd0,
		CFG_ALLOW_DIAG  = 3'd1,
		CFG_CUT_CORNERS = 3'd2,
		CFG_SQUEEZE     = 3'd3,
		CFG_WEIGHT      = 3'd4,
		CFG_GOAL_ROW    = 3'd5,
		CFG_GOAL_COL    = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MET_OCTILE    = 2'd0,
		MET_MANHATTAN = 2'd1,
		MET_EUCLID    = 2'd2,
		MET_CHEBYSHEV = 2'd3
	} metric_t;

	typedef struct packed {
		metric_t               metric;
		logic                  allow_diag;
		logic                  cut_corners;
		logic                  allow_squeeze;
		logic [WEIGHT_W-1:0]   weight;
		logic [ROW_W-1:0]      goal_row;
		logic [ROW_W-1:0]      goal_col;
	} cfg_t;

	// one classified cell waiting for expansion
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [ROW_W-1:0]  col;
		logic [COST_W-1:0] cost;
		logic [MASK_W-1:0] succ_mask;
	} job_t;

	// per-successor fields carried along the back pipeline
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [ROW_W-1:0]  col;
		logic [COST_W-1:0] cost;
		logic              last;
		logic              none;
	} side_t;

	// clamp to the 24-bit cost range
	function automatic logic [COST_W-1:0] sat_cost(input logic [47:0] x);
		logic [COST_W-1:0] r;
		r = (x > 48'(COST_MAX)) ? COST_MAX : x[COST_W-1:0];
		return r;
	endfunction

endpackage

/* design/gne_in_if.sv */
`timescale 1ns / 1ps
// gne_in_if: input channel of the expander, one expanded cell per item
// depends on gne_pkg for field widths

interface gne_in_if;
	logic                           valid;
	logic                           ready;
	logic [gne_pkg::ROW_W-1:0]      cell_row;
	logic [gne_pkg::ROW_W-1:0]      cell_col;
	logic [gne_pkg::COST_W-1:0]     cell_cost;
	logic [gne_pkg::MASK_W-1:0]     free_mask;

	modport source (output valid, cell_row, cell_col, cell_cost, free_mask, input ready);
	modport sink (input valid, cell_row, cell_col, cell_cost, free_mask, output ready);
endinterface

/* design/gne_out_if.sv */
`timescale 1ns / 1ps
// gne_out_if: result channel of the expander, one successor per item
// depends on gne_pkg for field widths

interface gne_out_if;
	logic                           valid;
	logic                           ready;
	logic [gne_pkg::ROW_W-1:0]      next_row;
	logic [gne_pkg::ROW_W-1:0]      next_col;
	logic [gne_pkg::COST_W-1:0]     next_cost;
	logic [gne_pkg::COST_W-1:0]     estimate;
	logic [gne_pkg::COST_W-1:0]     priority_res;
	logic                           none_found;
	logic                           last;

	modport source (output valid, next_row, next_col, next_cost, estimate, priority_res,
		none_found, last, input ready);
	modport sink (input valid, next_row, next_col, next_cost, estimate, priority_res,
		none_found, last, output ready);
endinterface

/* design/gne_front.sv */
`timescale 1ns / 1ps
// gne_front: configuration registers and neighbour classification
// depends on gne_pkg and gne_in_if; feeds gne_queue

module gne_front #(
	parameter int unsigned GRID_SIDE = gne_pkg::GRID_SIDE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gne_in_if.sink                           cell_in,
	input  logic                             cfg_we,
	input  logic [gne_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gne_pkg::CFG_DATA_W-1:0]   cfg_data,
	output gne_pkg::cfg_t                    cfg,
	output logic                             push_valid,
	output gne_pkg::job_t                    push_job,
	input  logic                             push_ready
);

	localparam int unsigned BOUND = (GRID_SIDE < gne_pkg::FIELD_SPAN) ? GRID_SIDE
		: gne_pkg::FIELD_SPAN;
	localparam logic [gne_pkg::ROW_W:0] BOUND_V = (gne_pkg::ROW_W + 1)'(BOUND);

	gne_pkg::cfg_t cfg_q;

	logic [gne_pkg::ROW_W:0] row_x, col_x;
	logic rm_ok, rp_ok, r0_ok, cm_ok, cp_ok, c0_ok;
	logic [7:0] usable;
	logic [7:0] succ;

	// diagonal admission from its two orthogonal neighbours
	function automatic logic diag_ok(input logic own, input logic ud, input logic lr,
		input gne_pkg::cfg_t c);
		logic ok;
		ok = own && c.allow_diag &&
			((ud && lr) || ((ud != lr) && c.cut_corners) || (!ud && !lr && c.allow_squeeze));
		return ok;
	endfunction

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.metric        <= gne_pkg::MET_OCTILE;
			cfg_q.allow_diag    <= 1'b1;
			cfg_q.cut_corners   <= 1'b0;
			cfg_q.allow_squeeze <= 1'b0;
			cfg_q.weight        <= 12'd256;
			cfg_q.goal_row      <= '0;
			cfg_q.goal_col      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gne_pkg::CFG_METRIC:      cfg_q.metric <= gne_pkg::metric_t'(cfg_data[1:0]);
				gne_pkg::CFG_ALLOW_DIAG:  cfg_q.allow_diag <= cfg_data[0];
				gne_pkg::CFG_CUT_CORNERS: cfg_q.cut_corners <= cfg_data[0];
				gne_pkg::CFG_SQUEEZE:     cfg_q.allow_squeeze <= cfg_data[0];
				gne_pkg::CFG_WEIGHT:      cfg_q.weight <= cfg_data[gne_pkg::WEIGHT_W-1:0];
				gne_pkg::CFG_GOAL_ROW:    cfg_q.goal_row <= cfg_data[gne_pkg::ROW_W-1:0];
				gne_pkg::CFG_GOAL_COL:    cfg_q.goal_col <= cfg_data[gne_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// grid bound checks for each row and column offset
	always_comb begin
		row_x = {1'b0, cell_in.cell_row};
		col_x = {1'b0, cell_in.cell_col};
		rm_ok = (cell_in.cell_row != '0) && ((row_x - 1'b1) < BOUND_V);
		rp_ok = (row_x + 1'b1) < BOUND_V;
		r0_ok = row_x < BOUND_V;
		cm_ok = (cell_in.cell_col != '0) && ((col_x - 1'b1) < BOUND_V);
		cp_ok = (col_x + 1'b1) < BOUND_V;
		c0_ok = col_x < BOUND_V;
	end

	// free and on the grid
	always_comb begin
		usable[gne_pkg::DIR_UP]    = cell_in.free_mask[gne_pkg::DIR_UP] && rm_ok && c0_ok;
		usable[gne_pkg::DIR_DOWN]  = cell_in.free_mask[gne_pkg::DIR_DOWN] && rp_ok && c0_ok;
		usable[gne_pkg::DIR_LEFT]  = cell_in.free_mask[gne_pkg::DIR_LEFT] && r0_ok && cm_ok;
		usable[gne_pkg::DIR_RIGHT] = cell_in.free_mask[gne_pkg::DIR_RIGHT] && r0_ok && cp_ok;
		usable[gne_pkg::DIR_UL]    = cell_in.free_mask[gne_pkg::DIR_UL] && rm_ok && cm_ok;
		usable[gne_pkg::DIR_UR]    = cell_in.free_mask[gne_pkg::DIR_UR] && rm_ok && cp_ok;
		usable[gne_pkg::DIR_DL]    = cell_in.free_mask[gne_pkg::DIR_DL] && rp_ok && cm_ok;
		usable[gne_pkg::DIR_DR]    = cell_in.free_mask[gne_pkg::DIR_DR] && rp_ok && cp_ok;
	end

	// admissible successor set
	always_comb begin
		succ[3:0] = usable[3:0];
		succ[gne_pkg::DIR_UL] = diag_ok(usable[gne_pkg::DIR_UL], usable[gne_pkg::DIR_UP],
			usable[gne_pkg::DIR_LEFT], cfg_q);
		succ[gne_pkg::DIR_UR] = diag_ok(usable[gne_pkg::DIR_UR], usable[gne_pkg::DIR_UP],
			usable[gne_pkg::DIR_RIGHT], cfg_q);
		succ[gne_pkg::DIR_DL] = diag_ok(usable[gne_pkg::DIR_DL], usable[gne_pkg::DIR_DOWN],
			usable[gne_pkg::DIR_LEFT], cfg_q);
		succ[gne_pkg::DIR_DR] = diag_ok(usable[gne_pkg::DIR_DR], usable[gne_pkg::DIR_DOWN],
			usable[gne_pkg::DIR_RIGHT], cfg_q);
	end

	assign push_valid         = cell_in.valid;
	assign cell_in.ready      = push_ready;
	assign push_job.row       = cell_in.cell_row;
	assign push_job.col       = cell_in.cell_col;
	assign push_job.cost      = cell_in.cell_cost;
	assign push_job.succ_mask = succ;

endmodule

/* design/gne_queue.sv */
`timescale 1ns / 1ps
// gne_queue: small register fifo between classification and expansion
// depends on nothing but its parameters

module gne_queue #(
	parameter int unsigned WIDTH = 52,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q < DEPTH_V;
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_V)
		else $error("queue fill count beyond depth");

endmodule

/* design/gne_isqrt.sv */
`timescale 1ns / 1ps
// gne_isqrt: pipelined integer square root, two result bits per stage
// no package use; a payload rides along with each operand

module gne_isqrt #(
	parameter int unsigned XW = 38,
	parameter int unsigned PW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [XW-1:0]       radicand,
	input  logic [PW-1:0]       in_pay,
	output logic                out_valid,
	output logic [XW/2-1:0]     root,
	output logic [PW-1:0]       out_pay
);

	localparam int unsigned RW  = XW / 2;
	localparam int unsigned NST = (RW + 1) / 2;

	logic [XW-1:0] x_q    [NST];
	logic [RW+1:0] rem_q  [NST];
	logic [RW-1:0] root_q [NST];
	logic [PW-1:0] pay_q  [NST];
	logic          v_q    [NST];

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic [XW-1:0] x_in, x_nx;
		logic [RW+1:0] rem_in, rem_nx, trial;
		logic [RW-1:0] root_in, root_nx;
		logic [PW-1:0] pay_in;
		logic          v_in;

		if (g == 0) begin : g_first
			assign x_in    = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign pay_in  = in_pay;
			assign v_in    = in_valid;
		end else begin : g_next
			assign x_in    = x_q[g-1];
			assign rem_in  = rem_q[g-1];
			assign root_in = root_q[g-1];
			assign pay_in  = pay_q[g-1];
			assign v_in    = v_q[g-1];
		end

		// two digit-by-digit root steps
		always_comb begin
			x_nx    = x_in;
			rem_nx  = rem_in;
			root_nx = root_in;
			trial   = '0;
			for (int s = 0; s < 2; s++) begin
				if (g * 2 + s < RW) begin
					rem_nx = {rem_nx[RW-1:0], x_nx[XW-1 -: 2]};
					x_nx   = x_nx << 2;
					trial  = {root_nx, 2'b01};
					if (rem_nx >= trial) begin
						rem_nx  = rem_nx - trial;
						root_nx = {root_nx[RW-2:0], 1'b1};
					end else begin
						root_nx = {root_nx[RW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[g] <= 1'b0;
			end else if (en) begin
				v_q[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[g]    <= x_nx;
				rem_q[g]  <= rem_nx;
				root_q[g] <= root_nx;
				pay_q[g]  <= pay_in;
			end
		end
	end

	assign out_valid = v_q[NST-1];
	assign root      = root_q[NST-1];
	assign out_pay   = pay_q[NST-1];

endmodule

/* design/gne_back.sv */
`timescale 1ns / 1ps
// gne_back: walks the successor set of each queued cell and computes g, h and f
// depends on gne_pkg, gne_out_if and gne_isqrt

module gne_back #(
	parameter int unsigned COST_FRAC_BITS = gne_pkg::COST_FRAC_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gne_pkg::cfg_t   cfg,
	input  logic            head_valid,
	input  gne_pkg::job_t   head_job,
	output logic            pop,
	gne_out_if.source       succ_out
);

	localparam int unsigned F   = COST_FRAC_BITS;
	localparam int unsigned HW  = 12 + F;
	localparam int unsigned XW  = 22 + 2 * F;
	localparam int unsigned RW  = XW / 2;
	localparam logic [24:0] ONE_STEP = 25'(64'd1 << F);
	localparam logic [63:0] DIAG_STEP64 =
		(64'(gne_pkg::SQRT2_Q32) + (64'd1 << (31 - F))) >> (32 - F);
	localparam logic [24:0] DIAG_STEP = 25'(DIAG_STEP64);
	localparam logic [43:0] HALF = 44'(64'd1 << (31 - F));

	typedef struct packed {
		gne_pkg::side_t sb;
		logic [23:0]    oct;
		logic [23:0]    man;
		logic [23:0]    cheb;
	} sqpay_t;

	localparam int unsigned PW = $bits(sqpay_t);

	logic adv;
	logic started_q;
	logic [7:0] left_q;
	logic [7:0] mask, rest;
	logic [2:0] k;
	logic is_last, is_none, is_diag;
	logic [9:0] nr, nc;
	logic [24:0] ng_sum;
	gne_pkg::side_t sel_sb;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	gne_pkg::side_t sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic [9:0] dr, dc, lo, hi;
	logic [9:0] lo_s2, hi_s2, dr_s2, dc_s2;
	logic [20:0] sq_s3;
	logic [43:0] octp_s3;
	logic [9:0] diff_s3, cheb_s3;
	logic [10:0] man_s3;
	logic [HW-1:0] oct_raw, man_raw, cheb_raw;
	sqpay_t sq_in, sq_out;
	logic [PW-1:0] sq_out_vec;
	logic sq_valid;
	logic [RW-1:0] sq_root;
	logic [23:0] h_sel, h_s4, h_s5;
	logic [35:0] prod_s5;
	logic [28:0] f_raw;

	logic out_valid_q;
	logic [9:0] out_row_q, out_col_q;
	logic [23:0] out_cost_q, out_est_q, out_prio_q;
	logic out_none_q, out_last_q;

	// whole back pipeline moves when the output register can take a result
	assign adv = !out_valid_q || succ_out.ready;

	// pick the lowest remaining successor of the head cell
	always_comb begin
		mask = started_q ? left_q : head_job.succ_mask;
		k = '0;
		for (int i = 7; i >= 0; i--) begin
			if (mask[i]) k = 3'(i);
		end
		rest    = mask & ~(8'd1 << k);
		is_none = mask == '0;
		is_last = rest == '0;
		is_diag = k[2];
	end

	// successor position and cost
	always_comb begin
		unique case (k)
			gne_pkg::DIR_UP, gne_pkg::DIR_UL, gne_pkg::DIR_UR: nr = head_job.row - 10'd1;
			gne_pkg::DIR_DOWN, gne_pkg::DIR_DL, gne_pkg::DIR_DR: nr = head_job.row + 10'd1;
			default: nr = head_job.row;
		endcase
		unique case (k)
			gne_pkg::DIR_LEFT, gne_pkg::DIR_UL, gne_pkg::DIR_DL: nc = head_job.col - 10'd1;
			gne_pkg::DIR_RIGHT, gne_pkg::DIR_UR, gne_pkg::DIR_DR: nc = head_job.col + 10'd1;
			default: nc = head_job.col;
		endcase
		ng_sum = {1'b0, head_job.cost} + (is_diag ? DIAG_STEP : ONE_STEP);
		sel_sb.row  = is_none ? '0 : nr;
		sel_sb.col  = is_none ? '0 : nc;
		sel_sb.cost = is_none ? '0 : gne_pkg::sat_cost(48'(ng_sum));
		sel_sb.last = is_last;
		sel_sb.none = is_none;
	end

	assign pop = adv && head_valid && is_last;

	// walk state of the head cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (adv && head_valid) begin
			started_q <= !is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			left_q <= rest;
		end
	end

	// distances to the goal
	always_comb begin
		dr = (sb_s1.row > cfg.goal_row) ? sb_s1.row - cfg.goal_row : cfg.goal_row - sb_s1.row;
		dc = (sb_s1.col > cfg.goal_col) ? sb_s1.col - cfg.goal_col : cfg.goal_col - sb_s1.col;
		lo = (dr < dc) ? dr : dc;
		hi = (dr < dc) ? dc : dr;
	end

	// metric terms, sqrt radicand
	always_comb begin
		oct_raw  = (HW'(diff_s3) << F) + HW'(octp_s3 >> (32 - F));
		man_raw  = HW'(man_s3) << F;
		cheb_raw = HW'(cheb_s3) << F;
		sq_in.sb   = sb_s3;
		sq_in.oct  = gne_pkg::sat_cost(48'(oct_raw));
		sq_in.man  = gne_pkg::sat_cost(48'(man_raw));
		sq_in.cheb = gne_pkg::sat_cost(48'(cheb_raw));
	end

	gne_isqrt #(
		.XW (XW),
		.PW (PW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.radicand  (XW'(sq_s3) << (2 * F)),
		.in_pay    (sq_in),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_pay   (sq_out_vec)
	);

	// heuristic select
	always_comb begin
		sq_out = sqpay_t'(sq_out_vec);
		unique case (cfg.metric)
			gne_pkg::MET_OCTILE:    h_sel = sq_out.oct;
			gne_pkg::MET_MANHATTAN: h_sel = sq_out.man;
			gne_pkg::MET_EUCLID:    h_sel = gne_pkg::sat_cost(48'(sq_root));
			default:                h_sel = sq_out.cheb;
		endcase
	end

	assign f_raw = 29'(sb_s5.cost) + 29'(prod_s5 >> 8);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_valid;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// pipeline data
	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s1   <= sel_sb;
			sb_s2   <= sb_s1;
			dr_s2   <= dr;
			dc_s2   <= dc;
			lo_s2   <= lo;
			hi_s2   <= hi;
			sb_s3   <= sb_s2;
			sq_s3   <= 21'(dr_s2 * dr_s2) + 21'(dc_s2 * dc_s2);
			octp_s3 <= 44'(lo_s2 * gne_pkg::SQRT2_Q32) + HALF;
			diff_s3 <= hi_s2 - lo_s2;
			man_s3  <= 11'(dr_s2) + 11'(dc_s2);
			cheb_s3 <= hi_s2;
			sb_s4   <= sq_out.sb;
			h_s4    <= h_sel;
			sb_s5   <= sb_s4;
			h_s5    <= h_s4;
			prod_s5 <= 36'(cfg.weight * h_s4);
			out_row_q  <= sb_s5.row;
			out_col_q  <= sb_s5.col;
			out_cost_q <= sb_s5.cost;
			out_est_q  <= sb_s5.none ? '0 : h_s5;
			out_prio_q <= sb_s5.none ? '0 : gne_pkg::sat_cost(48'(f_raw));
			out_none_q <= sb_s5.none;
			out_last_q <= sb_s5.last;
		end
	end

	assign succ_out.valid        = out_valid_q;
	assign succ_out.next_row     = out_row_q;
	assign succ_out.next_col     = out_col_q;
	assign succ_out.next_cost    = out_cost_q;
	assign succ_out.estimate     = out_est_q;
	assign succ_out.priority_res = out_prio_q;
	assign succ_out.none_found   = out_none_q;
	assign succ_out.last         = out_last_q;

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_none_q |-> out_last_q && (out_cost_q == '0))
		else $error("empty result not marked last or carries a cost");

	a_walk_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("successor walk without a queued cell");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1 && sb_s1.last)
		else $error("cell released without its final result");

endmodule

/* design/grid_neighbour_expander_core.sv */
`timescale 1ns / 1ps
// grid_neighbour_expander_core: top level of the A* successor generator
// depends on gne_pkg, gne_in_if, gne_out_if, gne_front, gne_queue, gne_back

// Each expanded cell yields its admissible neighbours (orthogonal first, then
// diagonal) as one result per cycle while the result side does not stall, or a
// single none_found result, so a cell gives at most eight results, taken in turn
// by the successor walk in the back end. Cells are classified on entry and wait in a
// four-deep queue, so a new cell is taken while earlier ones are expanding.
// Most of the path from a cell to its first result is the pipelined square root
// of the euclidean metric.
// Configuration must be written only while the block is idle (not enforced).

module grid_neighbour_expander_core #(
	parameter int unsigned GRID_SIDE      = gne_pkg::GRID_SIDE_DEF,
	parameter int unsigned COST_FRAC_BITS = gne_pkg::COST_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gne_in_if.sink                           cell_in,
	gne_out_if.source                        succ_out,
	input  logic                             cfg_we,
	input  logic [gne_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gne_pkg::CFG_DATA_W-1:0]   cfg_data
);

	gne_pkg::cfg_t cfg;
	gne_pkg::job_t push_job, head_job;
	logic push_valid, push_ready, head_valid, pop;
	logic [$bits(gne_pkg::job_t)-1:0] head_vec;

	// classification and registers
	gne_front #(
		.GRID_SIDE (GRID_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_in    (cell_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	// decoupling queue
	gne_queue #(
		.WIDTH ($bits(gne_pkg::job_t)),
		.DEPTH (gne_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_data  (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_vec)
	);

	assign head_job = gne_pkg::job_t'(head_vec);

	// successor expansion
	gne_back #(
		.COST_FRAC_BITS (COST_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.succ_out   (succ_out)
	);

endmodule

/* sim/tb_grid_neighbour_expander_core.sv */
`timescale 1ns / 1ps
// tb_grid_neighbour_expander_core: self-checking bench for the successor generator
// depends on gne_pkg, gne_in_if, gne_out_if and grid_neighbour_expander_core

module tb_grid_neighbour_expander_core;

	localparam logic [gne_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int unsigned FRAC = gne_pkg::COST_FRAC_DEF;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [gne_pkg::ROW_W-1:0]  row;
		logic [gne_pkg::ROW_W-1:0]  col;
		logic [gne_pkg::COST_W-1:0] cost;
		logic [gne_pkg::MASK_W-1:0] mask;
	} cell_t;

	typedef struct {
		logic [gne_pkg::ROW_W-1:0]  row;
		logic [gne_pkg::ROW_W-1:0]  col;
		logic [gne_pkg::COST_W-1:0] cost;
		logic [gne_pkg::COST_W-1:0] est;
		logic [gne_pkg::COST_W-1:0] prio;
		logic                       none;
		logic                       last;
	} succ_t;

	// directed row: typed marks an expectation written in by hand
	typedef struct {
		cell_t stim;
		bit    typed;
		succ_t want;
	} vec_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [gne_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gne_pkg::CFG_DATA_W-1:0] cfg_data;

	gne_in_if cell_in ();
	gne_out_if succ_out ();

	gne_pkg::cfg_t model_cfg;
	succ_t succ_expect[$];
	int errors;
	bit quiet;
	int stall_left;

	grid_neighbour_expander_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_in   (cell_in.sink),
		.succ_out  (succ_out.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// fixed-point helpers
	function automatic longint unsigned diag_cost(input longint unsigned n);
		return (n * 64'd6074001000 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
	endfunction

	function automatic longint unsigned int_root(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned goal_estimate(input longint unsigned r,
		input longint unsigned c);
		longint unsigned dr, dc, lo, hi, h;
		dr = (r > model_cfg.goal_row) ? r - model_cfg.goal_row : model_cfg.goal_row - r;
		dc = (c > model_cfg.goal_col) ? c - model_cfg.goal_col : model_cfg.goal_col - c;
		lo = (dr < dc) ? dr : dc;
		hi = (dr < dc) ? dc : dr;
		case (model_cfg.metric)
			gne_pkg::MET_OCTILE:    h = ((hi - lo) << FRAC) + diag_cost(lo);
			gne_pkg::MET_MANHATTAN: h = (dr + dc) << FRAC;
			gne_pkg::MET_EUCLID:    h = int_root((dr * dr + dc * dc) << (2 * FRAC));
			default:                h = hi << FRAC;
		endcase
		return (h > gne_pkg::COST_MAX) ? gne_pkg::COST_MAX : h;
	endfunction

	// neighbour k is flagged free and inside the grid
	function automatic bit nb_open(input cell_t c, input int k, output int nr,
		output int nc);
		int dr[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
		int dc[8] = '{0, 0, -1, 1, -1, 1, -1, 1};
		nr = int'(c.row) + dr[k];
		nc = int'(c.col) + dc[k];
		return c.mask[k] && nr >= 0 && nc >= 0 && nr < int'(gne_pkg::FIELD_SPAN)
			&& nc < int'(gne_pkg::FIELD_SPAN);
	endfunction

	// successors of one cell, in output order
	task automatic expand_cell(input cell_t c);
		int k, nr, nc, tr, tc, n;
		bit ud, lr, ok;
		longint unsigned ng, h, f;
		succ_t s;
		n = 0;
		for (k = 0; k < 8; k++) begin
			if (!nb_open(c, k, nr, nc))
				continue;
			if (k >= int'(gne_pkg::DIR_UL)) begin
				if (!model_cfg.allow_diag)
					continue;
				ud = nb_open(c, (k == gne_pkg::DIR_UL || k == gne_pkg::DIR_UR) ?
					gne_pkg::DIR_UP : gne_pkg::DIR_DOWN, tr, tc);
				lr = nb_open(c, (k == gne_pkg::DIR_UL || k == gne_pkg::DIR_DL) ?
					gne_pkg::DIR_LEFT : gne_pkg::DIR_RIGHT, tr, tc);
				ok = (ud && lr) || ((ud != lr) && model_cfg.cut_corners)
					|| (!ud && !lr && model_cfg.allow_squeeze);
				if (!ok)
					continue;
				ng = c.cost + diag_cost(1);
			end else begin
				ng = c.cost + (64'd1 << FRAC);
			end
			if (ng > gne_pkg::COST_MAX)
				ng = gne_pkg::COST_MAX;
			h = goal_estimate(nr, nc);
			f = ng + ((model_cfg.weight * h) >> 8);
			if (f > gne_pkg::COST_MAX)
				f = gne_pkg::COST_MAX;
			s.row  = gne_pkg::ROW_W'(nr);
			s.col  = gne_pkg::ROW_W'(nc);
			s.cost = gne_pkg::COST_W'(ng);
			s.est  = gne_pkg::COST_W'(h);
			s.prio = gne_pkg::COST_W'(f);
			s.none = 1'b0;
			s.last = 1'b0;
			succ_expect.insert(succ_expect.size(), s);
			n++;
		end
		if (n == 0) begin
			s.row  = '0;
			s.col  = '0;
			s.cost = '0;
			s.est  = '0;
			s.prio = '0;
			s.none = 1'b1;
			s.last = 1'b1;
			succ_expect.insert(succ_expect.size(), s);
		end else begin
			succ_expect[$].last = 1'b1;
		end
	endtask

	// present one cell and hold it until taken; called just after an edge
	task automatic send_cell(input cell_t c);
		cell_in.valid <= 1'b1;
		cell_in.cell_row <= c.row;
		cell_in.cell_col <= c.col;
		cell_in.cell_cost <= c.cost;
		cell_in.free_mask <= c.mask;
		@(posedge clk);
		while (!cell_in.ready)
			@(posedge clk);
	endtask

	// random gap on the input side after an accepted item
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cell_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [gne_pkg::ROW_W-1:0] pick_coord(
		input logic [gne_pkg::ROW_W-1:0] goal);
		case ($urandom_range(0, 5))
			0: return 10'd0;
			1: return 10'd1;
			2: return 10'd1023;
			3: return 10'd1022;
			4: return goal + 10'($urandom_range(0, 6)) - 10'd3;
			default: return 10'($urandom);
		endcase
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		c.row = pick_coord(model_cfg.goal_row);
		c.col = pick_coord(model_cfg.goal_col);
		case ($urandom_range(0, 3))
			0: c.cost = gne_pkg::COST_MAX - 24'($urandom_range(0, 800));
			1: c.cost = 24'($urandom_range(0, 4096));
			default: c.cost = 24'($urandom);
		endcase
		c.mask = 8'($urandom);
		return c;
	endfunction

	// wait for every result, let the pipeline settle, then write all registers
	task automatic load_config(input gne_pkg::cfg_t v);
		logic [gne_pkg::CFG_DATA_W-1:0] vals[7];
		int i;
		cell_in.valid <= 1'b0;
		while (succ_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		vals = '{12'(v.metric), 12'(v.allow_diag), 12'(v.cut_corners),
			12'(v.allow_squeeze), v.weight, 12'(v.goal_row), 12'(v.goal_col)};
		for (i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= gne_pkg::CFG_METRIC + i[gne_pkg::CFG_IDX_W-1:0];
			// upper bits beyond the register width are noise
			cfg_data <= vals[i] | (gne_pkg::CFG_DATA_W'($urandom) <<
				(i == gne_pkg::CFG_WEIGHT ? 12 : (i >= gne_pkg::CFG_GOAL_ROW ? 10 :
				(i == gne_pkg::CFG_METRIC ? 2 : 1))));
			@(posedge clk);
		end
		// unused index must change nothing
		cfg_index <= CFG_UNUSED;
		cfg_data <= gne_pkg::CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		model_cfg = v;
	endtask

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			succ_out.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 5);
			succ_out.ready <= 1'b0;
		end else begin
			succ_out.ready <= 1'b1;
		end
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		succ_t w;
		if (arst_n && succ_out.valid && succ_out.ready) begin
			if (succ_expect.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d", $realtime,
					succ_out.next_row, succ_out.next_col);
				errors++;
			end else begin
				w = succ_expect.pop_front();
				if (succ_out.next_row !== w.row) begin
					$display("%0t: next_row exp %0d got %0d", $realtime, w.row,
						succ_out.next_row);
					errors++;
				end
				if (succ_out.next_col !== w.col) begin
					$display("%0t: next_col exp %0d got %0d", $realtime, w.col,
						succ_out.next_col);
					errors++;
				end
				if (succ_out.next_cost !== w.cost) begin
					$display("%0t: next_cost exp %h got %h", $realtime, w.cost,
						succ_out.next_cost);
					errors++;
				end
				if (succ_out.estimate !== w.est) begin
					$display("%0t: estimate exp %h got %h", $realtime, w.est,
						succ_out.estimate);
					errors++;
				end
				if (succ_out.priority_res !== w.prio) begin
					$display("%0t: priority_res exp %h got %h", $realtime, w.prio,
						succ_out.priority_res);
					errors++;
				end
				if (succ_out.none_found !== w.none) begin
					$display("%0t: none_found exp %b got %b", $realtime, w.none,
						succ_out.none_found);
					errors++;
				end
				if (succ_out.last !== w.last) begin
					$display("%0t: last exp %b got %b", $realtime, w.last, succ_out.last);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// stimulus
	initial begin
		vec_t vecs[$];
		gne_pkg::cfg_t phases[$];
		gne_pkg::cfg_t pc;
		cell_t rc;
		int i;
		errors = 0;
		quiet = 1'b0;
		stall_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = gne_pkg::CFG_METRIC;
		cfg_data = '0;
		cell_in.valid = 1'b0;
		cell_in.cell_row = '0;
		cell_in.cell_col = '0;
		cell_in.cell_cost = '0;
		cell_in.free_mask = '0;
		succ_out.ready = 1'b0;
		model_cfg = '{gne_pkg::MET_OCTILE, 1'b1, 1'b0, 1'b0, 12'd256, 10'd0, 10'd0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cells under the reset settings
		vecs = '{
			'{'{0, 0, 0, 8'h00}, 1, '{0, 0, 0, 0, 0, 1, 1}},
			'{'{0, 0, 0, 8'h11}, 1, '{0, 0, 0, 0, 0, 1, 1}},
			'{'{5, 0, 24'hFFFFFF, 8'h01}, 1, '{4, 0, 24'hFFFFFF, 24'd1024, 24'hFFFFFF, 0, 1}},
			'{'{512, 512, 0, 8'hF0}, 1, '{0, 0, 0, 0, 0, 1, 1}},
			'{'{512, 512, 0, 8'h11}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{1023, 1023, 0, 8'hFF}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{0, 1023, 0, 8'hFF}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{1023, 0, 123, 8'hFF}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{1, 1, 256, 8'hFF}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{512, 512, 0, 8'h15}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{300, 700, 24'h123456, 8'hAA}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{10, 10, 24'hFFFF00, 8'h0F}, 0, '{0, 0, 0, 0, 0, 0, 0}},
			'{'{1022, 1, 24'hFFFFFE, 8'h55}, 0, '{0, 0, 0, 0, 0, 0, 0}}
		};
		foreach (vecs[j]) begin
			send_cell(vecs[j].stim);
			if (vecs[j].typed)
				succ_expect.insert(succ_expect.size(), vecs[j].want);
			else
				expand_cell(vecs[j].stim);
			sender_gap();
		end

		// settings phases: extremes first, then random ones
		phases = '{
			'{gne_pkg::MET_OCTILE, 1'b1, 1'b1, 1'b0, 12'd4095, 10'd1023, 10'd1023},
			'{gne_pkg::MET_MANHATTAN, 1'b1, 1'b0, 1'b1, 12'd0, 10'd0, 10'd1023},
			'{gne_pkg::MET_EUCLID, 1'b1, 1'b1, 1'b1, 12'd256, 10'd1023, 10'd0},
			'{gne_pkg::MET_CHEBYSHEV, 1'b0, 1'b0, 1'b0, 12'd4095, 10'd512, 10'd512}
		};
		repeat (3) begin
			pc.metric = gne_pkg::metric_t'($urandom_range(0, 3));
			pc.allow_diag = $urandom_range(0, 3) != 0;
			pc.cut_corners = 1'($urandom);
			pc.allow_squeeze = 1'($urandom);
			pc.weight = 12'($urandom);
			pc.goal_row = 10'($urandom);
			pc.goal_col = 10'($urandom);
			phases.insert(phases.size(), pc);
		end
		foreach (phases[p]) begin
			load_config(phases[p]);
			quiet = (p == phases.size() - 1);
			for (i = 0; i < 28; i++) begin
				rc = random_cell();
				send_cell(rc);
				expand_cell(rc);
				sender_gap();
			end
		end
		cell_in.valid <= 1'b0;

		// drain
		while (succ_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
